>>> sv/dbdn_pkg.sv
// Shared types and constants for the detection box decode and suppression block.
// Used by every module of the block but the checker; depends on nothing.
package dbdn_pkg;

  localparam int unsigned CAP      = 64;
  localparam int unsigned IDX_W    = $clog2(CAP);
  localparam int unsigned CNT_W    = $clog2(CAP + 1);
  localparam int unsigned EDGE_W   = 17;
  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned AREA_W   = 2 * EDGE_W;
  localparam int unsigned UNI_W    = AREA_W + 1;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;
  localparam logic [EDGE_W-1:0] EDGE_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_CONF_THR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVL_THR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT  = 3'd6;

  typedef struct packed {
    logic [15:0] conf_thr;
    logic [15:0] ovl_thr;
    logic [11:0] pad_x;
    logic [11:0] pad_y;
    logic [23:0] inv_scale;
    logic [13:0] img_width;
    logic [13:0] img_height;
  } cfg_t;

  // One decoded box as handed from the front to the back.
  typedef struct packed {
    logic               keep;
    logic               last;
    logic [EDGE_W-1:0]  x1;
    logic [EDGE_W-1:0]  x2;
    logic [EDGE_W-1:0]  y1;
    logic [EDGE_W-1:0]  y2;
    logic [SCORE_W-1:0] score;
    logic               cls;
  } cand_t;

  typedef struct packed {
    logic               box_valid;
    logic [EDGE_W-1:0]  x1;
    logic [EDGE_W-1:0]  y1;
    logic [EDGE_W-1:0]  x2;
    logic [EDGE_W-1:0]  y2;
    logic [SCORE_W-1:0] score;
    logic               cls;
    logic               ovf;
    logic               final_res;
  } res_t;

endpackage

>>> sv/detection_box_decode_nms.sv
// Top level of the detection box decode and greedy suppression block.
// Depends on dbdn_pkg, dbdn_front, dbdn_fifo and dbdn_back.
//
//   channel   handshake                  words carried
//   input     push / full                one raw box with two class scores
//   result    empty / pop                one kept box, or an empty-frame marker
//   config    cfg_valid_i / cfg_ready_o  register index and write data
//
// The front captures a box word, then for each of the four corners runs a
// multiply step and a round-and-clamp step on its one 18x24 multiplier, then
// hands the decoded box to a two-entry queue. While loading, the back pops
// each queued box and stores the kept ones. After the last box of a frame the
// back runs suppression: each pick scans all n stored boxes, and each kept box
// then scans all n again, skipping boxes already settled and running the
// overlap test on each open box. Reset clears all control state; the
// candidate store needs no clearing, since only entries written in the
// current frame are read. The front and the back stall independently: full
// rises while a box is decoded or the queue is full, and a waiting result
// does not keep the front from accepting new words.
module detection_box_decode_nms import dbdn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  logic [15:0]          center_x_i,
  input  logic [15:0]          center_y_i,
  input  logic [15:0]          box_width_i,
  input  logic [15:0]          box_height_i,
  input  logic [15:0]          score_zero_i,
  input  logic [15:0]          score_one_i,
  input  logic                 final_box_i,
  output logic                 empty,
  input  logic                 pop,
  output logic                 box_valid_o,
  output logic [16:0]          left_edge_o,
  output logic [16:0]          top_edge_o,
  output logic [16:0]          right_edge_o,
  output logic [16:0]          bottom_edge_o,
  output logic [15:0]          kept_score_o,
  output logic                 class_id_o,
  output logic                 overflowed_o,
  output logic                 final_result_o
);

  cfg_t  cfg_q;
  logic  q_push, q_full, q_pop, q_empty, res_valid;
  cand_t q_wdata, q_rdata;
  res_t  res;

  // Configuration registers; writes are always taken, unknown indexes dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conf_thr   <= 16'd16384;
      cfg_q.ovl_thr    <= 16'd29491;
      cfg_q.pad_x      <= 12'd0;
      cfg_q.pad_y      <= 12'd0;
      cfg_q.inv_scale  <= 24'd65536;
      cfg_q.img_width  <= 14'd640;
      cfg_q.img_height <= 14'd640;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CONF_THR:   cfg_q.conf_thr   <= cfg_data_i[15:0];
        REG_OVL_THR:    cfg_q.ovl_thr    <= cfg_data_i[15:0];
        REG_PAD_X:      cfg_q.pad_x      <= cfg_data_i[11:0];
        REG_PAD_Y:      cfg_q.pad_y      <= cfg_data_i[11:0];
        REG_INV_SCALE:  cfg_q.inv_scale  <= cfg_data_i[23:0];
        REG_IMG_WIDTH:  cfg_q.img_width  <= cfg_data_i[13:0];
        REG_IMG_HEIGHT: cfg_q.img_height <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  dbdn_front u_front (
    .clk_i, .rst_ni,
    .cfg_i        (cfg_q),
    .push_i       (push),
    .full_o       (full),
    .center_x_i, .center_y_i, .box_width_i, .box_height_i,
    .score_zero_i, .score_one_i, .final_box_i,
    .q_push_o     (q_push),
    .q_data_o     (q_wdata),
    .q_full_i     (q_full)
  );

  dbdn_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  dbdn_back u_back (
    .clk_i, .rst_ni,
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

  assign empty          = !res_valid;
  assign box_valid_o    = res.box_valid;
  assign left_edge_o    = res.x1;
  assign top_edge_o     = res.y1;
  assign right_edge_o   = res.x2;
  assign bottom_edge_o  = res.y2;
  assign kept_score_o   = res.score;
  assign class_id_o     = res.cls;
  assign overflowed_o   = res.ovf;
  assign final_result_o = res.final_res;

endmodule

>>> sv/dbdn_front.sv
// Front end: takes one raw box, picks class and score, maps the four corners.
// Depends on dbdn_pkg; feeds dbdn_fifo.
module dbdn_front import dbdn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic [15:0] center_x_i,
  input  logic [15:0] center_y_i,
  input  logic [15:0] box_width_i,
  input  logic [15:0] box_height_i,
  input  logic [15:0] score_zero_i,
  input  logic [15:0] score_one_i,
  input  logic        final_box_i,
  output logic        q_push_o,
  output cand_t       q_data_o,
  input  logic        q_full_i
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_RND, F_PUSH} fstate_e;
  typedef enum logic [1:0] {C_X1, C_X2, C_Y1, C_Y2} corner_e;

  fstate_e state_q, state_d;
  corner_e corner_q, corner_d;

  logic [15:0] cx_q, cy_q, bw_q, bh_q;
  logic [15:0] score_q;
  logic        cls_q, last_q, pass_q;
  logic [EDGE_W-1:0] edge_q [4];
  logic [41:0] prod_q;

  logic signed [19:0] diff;
  logic [15:0] cen, siz;
  logic [11:0] pad;
  logic        sub;
  logic [42:0] rnd;
  logic [25:0] val;
  logic [EDGE_W-1:0] lim, lim_x, lim_y;

  function automatic logic [EDGE_W-1:0] edge_limit(input logic [13:0] size);
    logic [17:0] l;
    l = {size - 14'd1, 4'b0000};
    if (size == '0) return '0;
    if (l > {1'b0, EDGE_MAX}) return EDGE_MAX;
    return l[EDGE_W-1:0];
  endfunction

  assign lim_x = edge_limit(cfg_i.img_width);
  assign lim_y = edge_limit(cfg_i.img_height);

  always_comb begin
    case (corner_q)
      C_X1: begin cen = cx_q; siz = bw_q; pad = cfg_i.pad_x; sub = 1'b1; lim = lim_x; end
      C_X2: begin cen = cx_q; siz = bw_q; pad = cfg_i.pad_x; sub = 1'b0; lim = lim_x; end
      C_Y1: begin cen = cy_q; siz = bh_q; pad = cfg_i.pad_y; sub = 1'b1; lim = lim_y; end
      C_Y2: begin cen = cy_q; siz = bh_q; pad = cfg_i.pad_y; sub = 1'b0; lim = lim_y; end
      default: begin cen = cx_q; siz = bw_q; pad = cfg_i.pad_x; sub = 1'b1; lim = lim_x; end
    endcase
    diff = sub ? $signed({3'b000, cen, 1'b0}) - $signed({4'b0000, siz})
               : $signed({3'b000, cen, 1'b0}) + $signed({4'b0000, siz});
    diff = diff - $signed({3'b000, pad, 5'b00000});
    rnd  = {1'b0, prod_q} + 43'(1 << 16);
    val  = rnd[42:17];
  end

  always_comb begin
    state_d  = state_q;
    corner_d = corner_q;
    case (state_q)
      F_IDLE: if (push_i) begin
        state_d  = F_MUL;
        corner_d = C_X1;
      end
      F_MUL: state_d = F_RND;
      F_RND: begin
        if (corner_q == C_Y2) begin
          state_d = F_PUSH;
        end else begin
          corner_d = corner_e'(corner_q + 2'd1);
          state_d  = F_MUL;
        end
      end
      F_PUSH: if (!q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      corner_q <= C_X1;
    end else begin
      state_q  <= state_d;
      corner_q <= corner_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push_i) begin
      cx_q    <= center_x_i;
      cy_q    <= center_y_i;
      bw_q    <= box_width_i;
      bh_q    <= box_height_i;
      cls_q   <= (score_zero_i < score_one_i);
      score_q <= (score_zero_i >= score_one_i) ? score_zero_i : score_one_i;
      pass_q  <= (((score_zero_i >= score_one_i) ? score_zero_i : score_one_i)
                  >= cfg_i.conf_thr);
      last_q  <= final_box_i;
    end
    if (state_q == F_MUL) begin
      // A corner left of or on the pad maps to zero.
      if (diff[19] || diff == '0) prod_q <= '0;
      else                        prod_q <= 42'(diff[17:0]) * 42'(cfg_i.inv_scale);
    end
    if (state_q == F_RND) begin
      edge_q[corner_q] <= (val > 26'(lim)) ? lim : val[EDGE_W-1:0];
    end
  end

  assign full_o   = (state_q != F_IDLE);
  assign q_push_o = (state_q == F_PUSH) && !q_full_i;

  always_comb begin
    q_data_o.keep  = pass_q && (edge_q[C_X2] > edge_q[C_X1]) && (edge_q[C_Y2] > edge_q[C_Y1]);
    q_data_o.last  = last_q;
    q_data_o.x1    = edge_q[C_X1];
    q_data_o.x2    = edge_q[C_X2];
    q_data_o.y1    = edge_q[C_Y1];
    q_data_o.y2    = edge_q[C_Y2];
    q_data_o.score = score_q;
    q_data_o.cls   = cls_q;
  end

endmodule

>>> sv/dbdn_fifo.sv
// Two-entry queue of decoded boxes between the front and the back.
// Depends on dbdn_pkg.
module dbdn_fifo import dbdn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cand_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output cand_t data_o,
  output logic  empty_o
);

  cand_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

>>> sv/dbdn_back.sv
// Back end: stores candidates, runs greedy suppression at frame end, emits results.
// Depends on dbdn_pkg; reads from dbdn_fifo.
module dbdn_back import dbdn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  q_empty_i,
  input  cand_t q_data_i,
  output logic  q_pop_o,
  output res_t  res_o,
  output logic  res_valid_o,
  input  logic  res_pop_i
);

  typedef enum logic [3:0] {
    B_LOAD, B_PRD, B_PCMP, B_PEND, B_ARD, B_ALAT, B_AAREA, B_AEMIT,
    B_SRD, B_SGEO, B_SMUL, B_SUNI, B_STHR, B_SCMP, B_FIN
  } bstate_e;

  bstate_e state_q;

  logic [2*EDGE_W-1:0]  mem_x [CAP];
  logic [2*EDGE_W-1:0]  mem_y [CAP];
  logic [SCORE_W:0]     mem_s [CAP];
  logic [2*EDGE_W-1:0]  rd_x_q, rd_y_q;
  logic [SCORE_W:0]     rd_s_q;

  logic [IDX_W-1:0] addr_q, best_idx_q;
  logic [CNT_W-1:0] count_q;
  logic             ovf_q, best_valid_q;
  logic [SCORE_W-1:0] best_score_q;
  logic [CAP-1:0]   done_q;

  logic [EDGE_W-1:0] ax1_q, ax2_q, ay1_q, ay2_q;
  logic [SCORE_W:0]  as_q;
  logic [AREA_W-1:0] area_a_q, area_b_q, inter_q;
  logic [EDGE_W-1:0] w_q, h_q, bw_q, bh_q;
  logic [UNI_W-1:0]  uni_q;
  logic [UNI_W+15:0] thrp_q;

  res_t pend_q, out_q;
  logic pend_valid_q, out_valid_q, out_free, out_load;

  logic [EDGE_W-1:0] bx1, bx2, by1, by2, lx, rx, ty, by;
  logic              store, at_end;

  // Fills in the frame-level flags of a result word.
  function automatic res_t close_word(input res_t r, input logic ovf, input logic fin);
    res_t w;
    w = r;
    w.ovf = ovf;
    w.final_res = fin;
    return w;
  endfunction

  assign out_free    = !out_valid_q || res_pop_i;
  assign out_load    = out_free && ((state_q == B_AEMIT && pend_valid_q) || state_q == B_FIN);
  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;
  assign q_pop_o     = (state_q == B_LOAD) && !q_empty_i;
  assign store       = q_pop_o && q_data_i.keep && (count_q < CNT_W'(CAP));
  assign at_end      = (CNT_W'(addr_q) + CNT_W'(1) == count_q);

  assign bx1 = rd_x_q[EDGE_W-1:0];
  assign bx2 = rd_x_q[2*EDGE_W-1:EDGE_W];
  assign by1 = rd_y_q[EDGE_W-1:0];
  assign by2 = rd_y_q[2*EDGE_W-1:EDGE_W];
  assign lx  = (ax1_q > bx1) ? ax1_q : bx1;
  assign rx  = (ax2_q < bx2) ? ax2_q : bx2;
  assign ty  = (ay1_q > by1) ? ay1_q : by1;
  assign by  = (ay2_q < by2) ? ay2_q : by2;

  // Candidate store: one write port while loading, one registered read port.
  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_x[count_q[IDX_W-1:0]] <= {q_data_i.x2, q_data_i.x1};
      mem_y[count_q[IDX_W-1:0]] <= {q_data_i.y2, q_data_i.y1};
      mem_s[count_q[IDX_W-1:0]] <= {q_data_i.cls, q_data_i.score};
    end
    rd_x_q <= mem_x[addr_q];
    rd_y_q <= mem_y[addr_q];
    rd_s_q <= mem_s[addr_q];
  end

  // Datapath registers of the overlap test.
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_ALAT: begin
        ax1_q <= bx1; ax2_q <= bx2; ay1_q <= by1; ay2_q <= by2;
        as_q  <= rd_s_q;
      end
      B_AAREA: area_a_q <= AREA_W'(ax2_q - ax1_q) * AREA_W'(ay2_q - ay1_q);
      B_SGEO: begin
        w_q  <= (rx > lx) ? rx - lx : '0;
        h_q  <= (by > ty) ? by - ty : '0;
        bw_q <= (bx2 > bx1) ? bx2 - bx1 : '0;
        bh_q <= (by2 > by1) ? by2 - by1 : '0;
      end
      B_SMUL: begin
        inter_q  <= AREA_W'(w_q) * AREA_W'(h_q);
        area_b_q <= AREA_W'(bw_q) * AREA_W'(bh_q);
      end
      B_SUNI: uni_q <= UNI_W'(area_a_q) + UNI_W'(area_b_q) - UNI_W'(inter_q);
      B_STHR: thrp_q <= (UNI_W + 16)'(cfg_i.ovl_thr) * (UNI_W + 16)'(uni_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_LOAD;
      addr_q       <= '0;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      done_q       <= '0;
      best_valid_q <= 1'b0;
      best_idx_q   <= '0;
      best_score_q <= '0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (res_pop_i) out_valid_q <= 1'b0;
      case (state_q)
        B_LOAD: begin
          if (q_pop_o) begin
            if (store) count_q <= count_q + CNT_W'(1);
            else if (q_data_i.keep) ovf_q <= 1'b1;
            if (q_data_i.last) begin
              addr_q       <= '0;
              best_valid_q <= 1'b0;
              state_q      <= (count_q == '0 && !store) ? B_PEND : B_PRD;
            end
          end
        end
        B_PRD: state_q <= B_PCMP;
        B_PCMP: begin
          // Strictly greater keeps the earliest of equal scores.
          if (!done_q[addr_q] && (!best_valid_q || rd_s_q[SCORE_W-1:0] > best_score_q)) begin
            best_valid_q <= 1'b1;
            best_idx_q   <= addr_q;
            best_score_q <= rd_s_q[SCORE_W-1:0];
          end
          if (at_end) begin
            state_q <= B_PEND;
          end else begin
            addr_q  <= addr_q + IDX_W'(1);
            state_q <= B_PRD;
          end
        end
        B_PEND: begin
          if (best_valid_q) begin
            addr_q  <= best_idx_q;
            state_q <= B_ARD;
          end else begin
            state_q <= B_FIN;
          end
        end
        B_ARD: state_q <= B_ALAT;
        B_ALAT: begin
          done_q[best_idx_q] <= 1'b1;
          state_q <= B_AAREA;
        end
        B_AAREA: state_q <= B_AEMIT;
        B_AEMIT: begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) out_q <= close_word(pend_q, ovf_q, 1'b0);
            pend_valid_q     <= 1'b1;
            pend_q.box_valid <= 1'b1;
            pend_q.x1        <= ax1_q;
            pend_q.x2        <= ax2_q;
            pend_q.y1        <= ay1_q;
            pend_q.y2        <= ay2_q;
            pend_q.score     <= as_q[SCORE_W-1:0];
            pend_q.cls       <= as_q[SCORE_W];
            pend_q.ovf       <= 1'b0;
            pend_q.final_res <= 1'b0;
            addr_q  <= '0;
            state_q <= B_SRD;
          end
        end
        B_SRD: state_q <= B_SGEO;
        B_SGEO: begin
          if (!done_q[addr_q]) begin
            state_q <= B_SMUL;
          end else if (at_end) begin
            addr_q       <= '0;
            best_valid_q <= 1'b0;
            state_q      <= B_PRD;
          end else begin
            addr_q  <= addr_q + IDX_W'(1);
            state_q <= B_SRD;
          end
        end
        B_SMUL: state_q <= B_SUNI;
        B_SUNI: state_q <= B_STHR;
        B_STHR: state_q <= B_SCMP;
        B_SCMP: begin
          if ({1'b0, inter_q, 16'h0000} > thrp_q) begin
            done_q[addr_q] <= 1'b1;
          end
          if (at_end) begin
            addr_q       <= '0;
            best_valid_q <= 1'b0;
            state_q      <= B_PRD;
          end else begin
            addr_q  <= addr_q + IDX_W'(1);
            state_q <= B_SRD;
          end
        end
        B_FIN: begin
          if (out_free) begin
            out_q        <= close_word(pend_valid_q ? pend_q : res_t'('0), ovf_q, 1'b1);
            pend_valid_q <= 1'b0;
            count_q      <= '0;
            ovf_q        <= 1'b0;
            done_q       <= '0;
            state_q      <= B_LOAD;
          end
        end
        default: state_q <= B_LOAD;
      endcase
    end
  end

endmodule

>>> sv/dbdn_checker.sv
// Port-level checks of the detection box decode block, bound to its top level.
// Depends on detection_box_decode_nms.
module dbdn_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 push,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input logic                 box_valid_o,
  input logic [16:0]          left_edge_o,
  input logic [16:0]          top_edge_o,
  input logic [16:0]          right_edge_o,
  input logic [16:0]          bottom_edge_o,
  input logic [15:0]          kept_score_o,
  input logic                 class_id_o,
  input logic                 final_result_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(left_edge_o) && $stable(kept_score_o)
                          && $stable(final_result_o)))
    else $error("waiting result changed");

  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !box_valid_o) |-> (final_result_o && kept_score_o == '0 && !class_id_o
                                  && left_edge_o == '0 && right_edge_o == '0))
    else $error("empty-frame result malformed");

  a_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && box_valid_o) |-> (right_edge_o > left_edge_o && bottom_edge_o > top_edge_o))
    else $error("kept box without positive area");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("front took a second word while decoding");

endmodule

bind detection_box_decode_nms dbdn_checker u_dbdn_checker (.*);

>>> tb/detection_box_decode_nms_test.sv
// Self-checking testbench for the detection box decode and suppression block.
// Predicts kept boxes with its own decode and greedy suppression; depends on dbdn_pkg and detection_box_decode_nms.
`timescale 1ns / 1ps
module detection_box_decode_nms_test;
  import dbdn_pkg::*;

  typedef struct {
    logic [15:0] cx, cy, bw, bh, s0, s1;
    logic        last;
  } box_word_t;

  // Register file as the predictor sees it, kept in step with every write.
  logic [15:0] conf_thr, ovl_thr;
  logic [11:0] pad_x, pad_y;
  logic [23:0] inv_scale;
  logic [13:0] img_w, img_h;

  // The predictor's own copy of the candidate store.
  logic [16:0] st_x1[CAP], st_x2[CAP], st_y1[CAP], st_y2[CAP];
  logic [15:0] st_score[CAP];
  logic        st_cls[CAP];
  int          st_count;
  logic        st_ovf;

  box_word_t pending_boxes[$];
  res_t      expected_boxes[$];

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic push, full, empty, pop;
  logic [15:0] cx_d, cy_d, bw_d, bh_d, s0_d, s1_d;
  logic last_d;
  res_t got;

  int   errors;
  int   cycle_cnt;
  int   burst_left, gap_left;
  logic hold_off;
  int   stall_mode;

  detection_box_decode_nms i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .push(push), .full(full),
    .center_x_i(cx_d), .center_y_i(cy_d), .box_width_i(bw_d), .box_height_i(bh_d),
    .score_zero_i(s0_d), .score_one_i(s1_d), .final_box_i(last_d),
    .empty(empty), .pop(pop),
    .box_valid_o(got.box_valid), .left_edge_o(got.x1), .top_edge_o(got.y1),
    .right_edge_o(got.x2), .bottom_edge_o(got.y2), .kept_score_o(got.score),
    .class_id_o(got.cls), .overflowed_o(got.ovf), .final_result_o(got.final_res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Clamp limit in Q.4: (size - 1) * 16, saturating at the 17-bit maximum.
  function automatic logic [16:0] clamp_limit(logic [13:0] size);
    logic [31:0] lim;
    if (size == 0) return '0;
    lim = (32'(size) - 1) * 16;
    return (lim > 32'h1FFFF) ? 17'h1FFFF : lim[16:0];
  endfunction

  // Maps a Q.5 corner back to original pixels in Q.4, rounding half up.
  function automatic logic [16:0] unletterbox(longint corner2, logic [11:0] pad,
                                              logic [16:0] lim);
    longint diff;
    longint unsigned v;
    diff = corner2 - (longint'(pad) << 5);
    if (diff <= 0) return '0;
    v = (longint'(diff) * longint'(inv_scale) + (64'd1 << 16)) >> 17;
    return (v > lim) ? lim : v[16:0];
  endfunction

  function automatic logic boxes_overlap(int a, int b);
    longint unsigned lx, rx, ty, by, w, h, inter, area_a, area_b, uni;
    lx = (st_x1[a] > st_x1[b]) ? st_x1[a] : st_x1[b];
    rx = (st_x2[a] < st_x2[b]) ? st_x2[a] : st_x2[b];
    ty = (st_y1[a] > st_y1[b]) ? st_y1[a] : st_y1[b];
    by = (st_y2[a] < st_y2[b]) ? st_y2[a] : st_y2[b];
    w = (rx > lx) ? rx - lx : 0;
    h = (by > ty) ? by - ty : 0;
    inter = w * h;
    area_a = longint'(st_x2[a] - st_x1[a]) * longint'(st_y2[a] - st_y1[a]);
    area_b = longint'(st_x2[b] - st_x1[b]) * longint'(st_y2[b] - st_y1[b]);
    uni = area_a + area_b - inter;
    return (inter << 16) > longint'(ovl_thr) * uni;
  endfunction

  // Decodes one accepted box and, on the frame's last box, runs suppression.
  task automatic predict_kept_boxes(box_word_t w);
    logic        cls;
    logic [15:0] score;
    logic [16:0] lx, ly, x1, x2, y1, y2;
    int          order[CAP];
    logic        supp[CAP];
    int          i, j, kept;
    res_t        r;
    cls = (w.s0 >= w.s1) ? 1'b0 : 1'b1;
    score = cls ? w.s1 : w.s0;
    if (score >= conf_thr) begin
      lx = clamp_limit(img_w);
      ly = clamp_limit(img_h);
      x1 = unletterbox(2 * longint'(w.cx) - longint'(w.bw), pad_x, lx);
      x2 = unletterbox(2 * longint'(w.cx) + longint'(w.bw), pad_x, lx);
      y1 = unletterbox(2 * longint'(w.cy) - longint'(w.bh), pad_y, ly);
      y2 = unletterbox(2 * longint'(w.cy) + longint'(w.bh), pad_y, ly);
      if (x2 > x1 && y2 > y1) begin
        if (st_count < CAP) begin
          st_x1[st_count] = x1; st_x2[st_count] = x2;
          st_y1[st_count] = y1; st_y2[st_count] = y2;
          st_score[st_count] = score; st_cls[st_count] = cls;
          st_count++;
        end else begin
          st_ovf = 1'b1;
        end
      end
    end
    if (!w.last) return;
    // Stable sort by descending score, so equal scores keep arrival order.
    for (i = 0; i < st_count; i++) begin
      j = i;
      while (j > 0 && st_score[order[j-1]] < st_score[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
      supp[i] = 1'b0;
    end
    kept = 0;
    for (i = 0; i < st_count; i++) begin
      if (supp[order[i]]) continue;
      for (j = i + 1; j < st_count; j++)
        if (!supp[order[j]] && boxes_overlap(order[i], order[j])) supp[order[j]] = 1'b1;
      r = '{box_valid: 1'b1, x1: st_x1[order[i]], y1: st_y1[order[i]],
            x2: st_x2[order[i]], y2: st_y2[order[i]], score: st_score[order[i]],
            cls: st_cls[order[i]], ovf: st_ovf, final_res: 1'b0};
      expected_boxes = {expected_boxes, r};
      kept++;
    end
    if (kept == 0) begin
      r = '0;
      r.ovf = st_ovf;
      expected_boxes = {expected_boxes, r};
    end
    expected_boxes[$].final_res = 1'b1;
    st_count = 0;
    st_ovf = 1'b0;
  endtask

  // Register writes happen only with the block idle; the predictor follows.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CONF_THR:   conf_thr = val[15:0];
      REG_OVL_THR:    ovl_thr = val[15:0];
      REG_PAD_X:      pad_x = val[11:0];
      REG_PAD_Y:      pad_y = val[11:0];
      REG_INV_SCALE:  inv_scale = val;
      REG_IMG_WIDTH:  img_w = val[13:0];
      REG_IMG_HEIGHT: img_h = val[13:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] ct, logic [15:0] ot, logic [11:0] px,
                           logic [11:0] py, logic [23:0] sc, logic [13:0] iw,
                           logic [13:0] ih);
    write_reg(REG_CONF_THR, 24'(ct));
    write_reg(REG_OVL_THR, 24'(ot));
    write_reg(REG_PAD_X, 24'(px));
    write_reg(REG_PAD_Y, 24'(py));
    write_reg(REG_INV_SCALE, sc);
    write_reg(REG_IMG_WIDTH, 24'(iw));
    write_reg(REG_IMG_HEIGHT, 24'(ih));
  endtask

  // Waits until the block has drained: no box word waiting, no result due,
  // and the suppression pass of any frame that yields nothing yet has settled.
  task automatic wait_drained();
    while (pending_boxes.size() != 0 || expected_boxes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Appends one box word to the sender's queue.
  task automatic queue_box(box_word_t w);
    pending_boxes = {pending_boxes, w};
  endtask

  function automatic box_word_t make_box(logic [15:0] cx, cy, bw, bh, s0, s1,
                                         logic last);
    box_word_t w;
    w.cx = cx; w.cy = cy; w.bw = bw; w.bh = bh; w.s0 = s0; w.s1 = s1; w.last = last;
    return w;
  endfunction

  // Random frames: mostly plausible boxes clustered in the image so that
  // suppression has real overlaps to decide, with some raw noise mixed in.
  function automatic box_word_t rand_box(logic last);
    box_word_t w;
    int base_x, base_y;
    if ($urandom_range(0, 9) == 0) begin
      w = make_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), last);
    end else begin
      base_x = $urandom_range(0, 3) * 2400 + 400;
      base_y = $urandom_range(0, 3) * 2400 + 400;
      w.cx = 16'(base_x + $urandom_range(0, 600));
      w.cy = 16'(base_y + $urandom_range(0, 600));
      w.bw = 16'($urandom_range(16, 2400));
      w.bh = 16'($urandom_range(16, 2400));
      w.s0 = 16'($urandom);
      w.s1 = ($urandom_range(0, 4) == 0) ? w.s0 : 16'($urandom);
      w.last = last;
    end
    return w;
  endfunction

  // Driver: presents the oldest pending word in bursts with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (pending_boxes.size() != 0 && !hold_off && gap_left == 0) begin
        push <= 1'b1;
        cx_d <= pending_boxes[0].cx; cy_d <= pending_boxes[0].cy;
        bw_d <= pending_boxes[0].bw; bh_d <= pending_boxes[0].bh;
        s0_d <= pending_boxes[0].s0; s1_d <= pending_boxes[0].s1;
        last_d <= pending_boxes[0].last;
      end else begin
        push <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  // Acceptance of an input word: the predictor runs at the same edge.
  always @(posedge clk) begin
    if (rst_n && push && !full && pending_boxes.size() != 0) begin
      predict_kept_boxes(pending_boxes.pop_front());
      if (burst_left > 0) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(0, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      end
    end
  end

  // Monitor: checks every accepted result against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      if (expected_boxes.size() == 0) begin
        $error("unexpected result word: %p", got);
        errors++;
      end else begin
        want = expected_boxes.pop_front();
        if (got.box_valid !== want.box_valid) begin
          $error("box_valid: expected %0d, got %0d", want.box_valid, got.box_valid);
          errors++;
        end
        if (got.x1 !== want.x1) begin
          $error("left_edge: expected %0d, got %0d", want.x1, got.x1);
          errors++;
        end
        if (got.y1 !== want.y1) begin
          $error("top_edge: expected %0d, got %0d", want.y1, got.y1);
          errors++;
        end
        if (got.x2 !== want.x2) begin
          $error("right_edge: expected %0d, got %0d", want.x2, got.x2);
          errors++;
        end
        if (got.y2 !== want.y2) begin
          $error("bottom_edge: expected %0d, got %0d", want.y2, got.y2);
          errors++;
        end
        if (got.score !== want.score) begin
          $error("kept_score: expected %0d, got %0d", want.score, got.score);
          errors++;
        end
        if (got.cls !== want.cls) begin
          $error("class_id: expected %0d, got %0d", want.cls, got.cls);
          errors++;
        end
        if (got.ovf !== want.ovf) begin
          $error("overflowed: expected %0d, got %0d", want.ovf, got.ovf);
          errors++;
        end
        if (got.final_res !== want.final_res) begin
          $error("final_result: expected %0d, got %0d", want.final_res, got.final_res);
          errors++;
        end
      end
    end
  end

  // Receiver: stalls in phases that change now and then, including none.
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 3) != 0);
      2: pop <= ($urandom_range(0, 1) != 0);
      default: pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int n, k, f;
    errors = 0; cycle_cnt = 0; burst_left = 0; gap_left = 0; hold_off = 1'b1;
    stall_mode = 0;
    rst_n = 1'b0; push = 1'b0; pop = 1'b0; cfg_valid = 1'b0;
    cfg_index = '0; cfg_data = '0;
    cx_d = '0; cy_d = '0; bw_d = '0; bh_d = '0; s0_d = '0; s1_d = '0; last_d = 1'b0;
    conf_thr = 16384; ovl_thr = 29491; pad_x = 0; pad_y = 0;
    inv_scale = 65536; img_w = 640; img_h = 640;
    st_count = 0; st_ovf = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed frames under reset settings: field extremes, ties, a dropped
    // box, a zero-area box, an empty frame and a heavy overlap pair.
    queue_box(make_box(16'd1600, 16'd1600, 16'd800, 16'd800,
                       16'd40000, 16'd40000, 1'b0));
    queue_box(make_box(16'd1650, 16'd1620, 16'd800, 16'd780,
                       16'd100, 16'd40000, 1'b0));
    queue_box(make_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 16'h0000, 1'b0));
    queue_box(make_box(16'd0, 16'd0, 16'd0, 16'd0,
                       16'h0000, 16'hFFFF, 1'b0));
    queue_box(make_box(16'd3000, 16'd3000, 16'd400, 16'd400,
                       16'd16383, 16'd100, 1'b0));
    queue_box(make_box(16'd5000, 16'd2000, 16'd400, 16'd400,
                       16'd16384, 16'd16384, 1'b1));
    queue_box(make_box(16'd100, 16'd100, 16'd10, 16'd10,
                       16'd0, 16'd0, 1'b1));
    hold_off = 1'b0;
    wait_drained();
    hold_off = 1'b1;

    // Overflow: a frame of more boxes than the store holds.
    write_all(16'd0, 16'hFFFF, 12'd0, 12'd0, 24'd65536, 14'd8192, 14'd8192);
    for (k = 0; k < CAP + 3; k++)
      queue_box(make_box(16'(200 + 900 * (k % 8)), 16'(200 + 900 * (k / 8)),
                         16'd300, 16'd300, 16'(k * 7), 16'd5,
                         k == CAP + 2));
    hold_off = 1'b0;
    wait_drained();
    hold_off = 1'b1;

    // Extreme settings: full pads, maximum and zero scale, tiny image.
    write_all(16'hFFFF, 16'd0, 12'hFFF, 12'hFFF, 24'hFFFFFF, 14'd1, 14'h3FFF);
    queue_box(make_box(16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000,
                       16'hFFFF, 16'hFFFF, 1'b1));
    hold_off = 1'b0;
    wait_drained();
    hold_off = 1'b1;
    write_all(16'd1, 16'd32768, 12'd7, 12'd3, 24'd0, 14'd0, 14'd640);
    queue_box(make_box(16'd800, 16'd800, 16'd200, 16'd200,
                       16'd5000, 16'd9, 1'b1));
    hold_off = 1'b0;
    wait_drained();
    hold_off = 1'b1;

    // Random phases, each with its own settings; frames are kept short.
    for (f = 0; f < 6; f++) begin
      write_all(16'($urandom_range(0, 30000)), 16'($urandom_range(0, 65535)),
                12'($urandom_range(0, 40)), 12'($urandom_range(0, 40)),
                24'($urandom_range(20000, 140000)),
                14'($urandom_range(200, 8192)), 14'($urandom_range(200, 8192)));
      n = 0;
      while (n < 50) begin
        k = $urandom_range(1, 12);
        for (int b = 0; b < k; b++) queue_box(rand_box(b == k - 1));
        n += k;
      end
      hold_off = 1'b0;
      // In the third phase the bench waits for the block to drain twice.
      if (f == 2) begin
        wait_drained();
      end
      wait_drained();
      hold_off = 1'b1;
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
